FILE: rtl/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and codes of the BER TLV stream parser.
// ----------------------------------------------------------------------------
package btp_pkg;

  localparam int unsigned DEF_MAX_DEPTH        = 16;
  localparam int unsigned DEF_MAX_LENGTH_BYTES = 4;

  localparam logic [1:0] ROLE_TAG    = 2'd0;
  localparam logic [1:0] ROLE_LENGTH = 2'd1;
  localparam logic [1:0] ROLE_VALUE  = 2'd2;
  localparam logic [1:0] ROLE_IGNORE = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TAG_LONG = 3'd1;
  localparam logic [2:0] ST_LEN_LONG = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_TOO_DEEP = 3'd4;
  localparam logic [2:0] ST_PAST_END = 3'd5;

  localparam logic [4:0] TAG_ESCAPE = 5'h1F;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic        header_done;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [20:0] tag_number;
    logic [31:0] value_length;
    logic        indefinite;
    logic [4:0]  nest_depth;
    logic [63:0] value_word;
    logic        value_done;
    logic [4:0]  levels_closed;
    logic [2:0]  status;
  } result_t;

endpackage

FILE: rtl/btp_if.sv
// ----------------------------------------------------------------------------
// btp_byte_if / btp_result_if
// Valid/ready channels for stream bytes and per-byte results.
// ----------------------------------------------------------------------------
interface btp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface btp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic        header_done;
  logic [1:0]  tag_class;
  logic        constructed;
  logic [20:0] tag_number;
  logic [31:0] value_length;
  logic        indefinite;
  logic [4:0]  nest_depth;
  logic [63:0] value_word;
  logic        value_done;
  logic [4:0]  levels_closed;
  logic [2:0]  status;
  modport source (output valid, output byte_role, output header_done, output tag_class,
                  output constructed, output tag_number, output value_length,
                  output indefinite, output nest_depth, output value_word,
                  output value_done, output levels_closed, output status, input ready);
  modport sink   (input valid, input byte_role, input header_done, input tag_class,
                  input constructed, input tag_number, input value_length,
                  input indefinite, input nest_depth, input value_word,
                  input value_done, input levels_closed, input status, output ready);
endinterface

FILE: rtl/ber_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser
// Streaming ASN.1 BER tag/length/value parser, one result per byte.
// ----------------------------------------------------------------------------
// A byte that does not end an item has its result registered in S_IN. A byte that
// ends an item (value end, empty item) goes on through S_CHK and S_OUT, with an
// S_RD and S_CHK pass for every definite level popped off the stack and an S_RD
// first for an end-of-contents item, since the stack sits in a one-port synchronous
// memory. The top entry is held in registers; total_length is read live.
module ber_tlv_stream_parser
  import btp_pkg::*;
#(
  parameter int unsigned MAX_DEPTH        = DEF_MAX_DEPTH,
  parameter int unsigned MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  btp_byte_if.sink     byte_in,
  btp_result_if.source result
);

  localparam int unsigned SP_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CNT_W = SP_W + 1;

  typedef enum logic [4:0] {
    PH_TAG_FIRST = 5'b00001,
    PH_TAG_EXT   = 5'b00010,
    PH_LEN_FIRST = 5'b00100,
    PH_LEN_MORE  = 5'b01000,
    PH_VALUE     = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    S_IN  = 4'b0001,
    S_RD  = 4'b0010,
    S_CHK = 4'b0100,
    S_OUT = 4'b1000
  } seq_t;

  logic [31:0] total_length;
  seq_t        seq;
  phase_t      phase, phase_next;
  logic [20:0] tag_acc, tag_acc_next;
  logic [1:0]  ext_cnt, ext_cnt_next;
  logic [2:0]  cls_form, cls_form_next;
  logic [31:0] len_acc, len_acc_next;
  logic [2:0]  len_left, len_left_next;
  logic [31:0] val_left, val_left_next;
  logic [63:0] val_acc, val_acc_next;
  logic [31:0] pos, pos_next;
  logic [SP_W-1:0] sp, sp_next;
  logic [2:0]  err, err_next;
  logic [31:0] top_end;
  logic        top_indef;
  logic [CNT_W-1:0] cnt;
  result_t     res, res_c, out_res;
  logic        out_valid;
  logic        out_load;

  logic [32:0] stack_mem [MAX_DEPTH+1];
  logic [32:0] rd_data;
  logic [SP_W-1:0] rd_addr;
  logic        push;
  logic [32:0] push_data;

  logic        accept, out_free, close, eoc;
  logic [2:0]  status;
  logic [31:0] bound;
  logic        fh_go, fh_indef;
  logic [31:0] fh_len;
  logic [32:0] fh_end;
  logic [7:0]  b;
  logic [6:0]  nlen;
  logic [31:0] la;
  logic [2:0]  ll;
  logic [31:0] vl;
  logic [63:0] va;
  logic        chk_pop;

  assign out_free     = !out_valid || result.ready;
  assign byte_in.ready = (seq == S_IN) && out_free;
  assign accept       = byte_in.valid && byte_in.ready;
  assign b            = byte_in.data_byte;
  assign bound        = (sp == '0) ? total_length : top_end;
  assign chk_pop      = (sp != '0) && !top_indef && (pos >= top_end);
  assign out_load     = (accept && !eoc && !close) || (seq == S_OUT && out_free);

  always_comb begin
    phase_next    = phase;
    tag_acc_next  = tag_acc;
    ext_cnt_next  = ext_cnt;
    cls_form_next = cls_form;
    len_acc_next  = len_acc;
    len_left_next = len_left;
    val_left_next = val_left;
    val_acc_next  = val_acc;
    pos_next      = pos;
    sp_next       = sp;
    err_next      = err;
    res_c         = '0;
    status        = ST_OK;
    close         = 1'b0;
    eoc           = 1'b0;
    push          = 1'b0;
    push_data     = '0;
    fh_go         = 1'b0;
    fh_indef      = 1'b0;
    fh_len        = '0;
    fh_end        = '0;
    nlen          = b[6:0];
    la            = {len_acc[23:0], b};
    ll            = (len_left != 3'd0) ? len_left - 3'd1 : 3'd0;
    vl            = (val_left != 32'd0) ? val_left - 32'd1 : 32'd0;
    va            = {val_acc[55:0], b};
    rd_addr       = sp - SP_W'(1);
    if (err != ST_OK) begin
      res_c.byte_role = ROLE_IGNORE;
      res_c.status    = err;
    end else if (phase == PH_TAG_FIRST && sp == '0 && pos >= total_length) begin
      res_c.byte_role = ROLE_IGNORE;
      res_c.status    = ST_PAST_END;
    end else begin
      res_c.byte_role = (phase == PH_VALUE) ? ROLE_VALUE :
                        ((phase == PH_TAG_FIRST || phase == PH_TAG_EXT) ? ROLE_TAG
                                                                        : ROLE_LENGTH);
      if (phase != PH_VALUE && pos >= bound) begin
        status = ST_OVERRUN;
      end else begin
        pos_next = pos + 32'd1;
        unique case (phase)
          PH_VALUE: begin
            val_acc_next  = va;
            val_left_next = vl;
            if (vl == 32'd0) begin
              res_c.value_done = 1'b1;
              res_c.value_word = (len_acc <= 32'd8) ? va : 64'd0;
              phase_next = PH_TAG_FIRST;
              close = 1'b1;
            end
          end
          PH_TAG_FIRST: begin
            cls_form_next = {b[7:6], b[5]};
            len_acc_next  = '0;
            ext_cnt_next  = '0;
            if (b[4:0] == TAG_ESCAPE) begin
              tag_acc_next = '0;
              phase_next   = PH_TAG_EXT;
            end else begin
              tag_acc_next = {16'd0, b[4:0]};
              phase_next   = PH_LEN_FIRST;
            end
          end
          PH_TAG_EXT: begin
            tag_acc_next = {tag_acc[13:0], b[6:0]};
            ext_cnt_next = ext_cnt + 2'd1;
            if (!b[7]) begin
              phase_next = PH_LEN_FIRST;
            end else if (ext_cnt_next == 2'd3) begin
              status = ST_TAG_LONG;
            end
          end
          PH_LEN_FIRST: begin
            if (!b[7]) begin
              fh_go  = 1'b1;
              fh_len = {24'd0, b};
            end else if (nlen == 7'd0) begin
              fh_go    = 1'b1;
              fh_indef = cls_form[0];
            end else if (32'(nlen) > MAX_LENGTH_BYTES) begin
              status = ST_LEN_LONG;
            end else begin
              len_acc_next  = '0;
              len_left_next = nlen[2:0];
              phase_next    = PH_LEN_MORE;
            end
          end
          PH_LEN_MORE: begin
            len_acc_next  = la;
            len_left_next = ll;
            if (ll == 3'd0) begin
              fh_go  = 1'b1;
              fh_len = la;
            end
          end
          default: ;
        endcase
        if (fh_go) begin
          len_acc_next      = fh_len;
          res_c.header_done = 1'b1;
          res_c.indefinite  = fh_indef;
          fh_end            = {1'b0, pos_next} + {1'b0, fh_len};
          if (!fh_indef && fh_end > {1'b0, bound}) begin
            status = ST_OVERRUN;
          end else begin
            phase_next = PH_TAG_FIRST;
            if (!cls_form[0]) begin
              if (fh_len == 32'd0) begin
                res_c.value_done = 1'b1;
                close = 1'b1;
                eoc = (cls_form[2:1] == 2'd0) && (tag_acc == '0) && (sp != '0) &&
                      top_indef;
              end else begin
                val_left_next = fh_len;
                val_acc_next  = '0;
                phase_next    = PH_VALUE;
              end
            end else if (fh_indef || fh_len != 32'd0) begin
              if (32'(sp) >= MAX_DEPTH) begin
                status = ST_TOO_DEEP;
              end else begin
                push      = 1'b1;
                push_data = fh_indef ? {bound, 1'b1} : {fh_end[31:0], 1'b0};
                sp_next   = sp + SP_W'(1);
              end
            end else begin
              close = 1'b1;
            end
          end
        end
      end
      res_c.tag_class    = cls_form_next[2:1];
      res_c.constructed  = cls_form_next[0];
      res_c.tag_number   = tag_acc_next;
      res_c.value_length = len_acc_next;
      res_c.nest_depth   = 5'(sp);
      if (status != ST_OK) begin
        err_next          = status;
        res_c.header_done = 1'b0;
        res_c.indefinite  = 1'b0;
        res_c.value_word  = '0;
        res_c.value_done  = 1'b0;
        close             = 1'b0;
        eoc               = 1'b0;
      end
      res_c.status = status;
      if (eoc) begin
        sp_next = sp - SP_W'(1);
        res_c.levels_closed = 5'd1;
      end
    end
    if (seq == S_CHK) begin
      rd_addr = sp - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      stack_mem[sp_next] <= push_data;
    end else begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
    end else if (cfg_wr_en) begin
      total_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IN;
      phase     <= PH_TAG_FIRST;
      tag_acc   <= '0;
      ext_cnt   <= '0;
      cls_form  <= '0;
      len_acc   <= '0;
      len_left  <= '0;
      val_left  <= '0;
      val_acc   <= '0;
      pos       <= '0;
      sp        <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (seq)
        S_IN: begin
          if (accept) begin
            phase    <= phase_next;
            tag_acc  <= tag_acc_next;
            ext_cnt  <= ext_cnt_next;
            cls_form <= cls_form_next;
            len_acc  <= len_acc_next;
            len_left <= len_left_next;
            val_left <= val_left_next;
            val_acc  <= val_acc_next;
            pos      <= pos_next;
            sp       <= sp_next;
            err      <= err_next;
            if (push) begin
              top_end   <= push_data[32:1];
              top_indef <= push_data[0];
            end
            if (eoc) begin
              res <= res_c;
              cnt <= CNT_W'(1);
              seq <= S_RD;
            end else if (close) begin
              res <= res_c;
              cnt <= '0;
              seq <= S_CHK;
            end else begin
              out_res <= res_c;
            end
          end
        end
        S_RD: begin
          top_end   <= rd_data[32:1];
          top_indef <= rd_data[0];
          seq       <= S_CHK;
        end
        S_CHK: begin
          if (chk_pop) begin
            sp  <= sp - SP_W'(1);
            cnt <= cnt + CNT_W'(1);
            seq <= S_RD;
          end else begin
            res.levels_closed <= 5'(cnt + CNT_W'((sp == '0) && (pos >= total_length)));
            seq <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_res <= res;
            seq     <= S_IN;
          end
        end
        default: seq <= S_IN;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.byte_role     = out_res.byte_role;
  assign result.header_done   = out_res.header_done;
  assign result.tag_class     = out_res.tag_class;
  assign result.constructed   = out_res.constructed;
  assign result.tag_number    = out_res.tag_number;
  assign result.value_length  = out_res.value_length;
  assign result.indefinite    = out_res.indefinite;
  assign result.nest_depth    = out_res.nest_depth;
  assign result.value_word    = out_res.value_word;
  assign result.value_done    = out_res.value_done;
  assign result.levels_closed = out_res.levels_closed;
  assign result.status        = out_res.status;

endmodule

FILE: tb/btp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btp_result_checker
// Watches the byte and result channels of the BER TLV parser, predicts the
// result of every accepted byte and compares it field by field.
// ----------------------------------------------------------------------------
module btp_result_checker
  import btp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  btp_byte_if         byte_mon,
  btp_result_if       res_mon,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int unsigned DEPTH_LIMIT = DEF_MAX_DEPTH;
  localparam int unsigned LEN_BYTES   = DEF_MAX_LENGTH_BYTES;

  typedef enum logic [2:0] {
    PH_TAG_FIRST, PH_TAG_EXT, PH_LEN_FIRST, PH_LEN_MORE, PH_VALUE
  } phase_t;

  logic [31:0] total_len;
  phase_t      phase;
  logic [20:0] tag_acc;
  logic [1:0]  ext_cnt;
  logic [2:0]  cls_form;
  logic [31:0] len_acc;
  logic [2:0]  len_left;
  logic [31:0] val_left;
  logic [63:0] val_acc;
  logic [31:0] pos;
  logic [31:0] lvl_end   [0:DEPTH_LIMIT];
  logic        lvl_indef [0:DEPTH_LIMIT];
  logic [4:0]  sp;
  logic [2:0]  sticky;

  result_t expected_results[$];

  function automatic logic [31:0] level_bound();
    if (sp == 0 || sp > DEPTH_LIMIT) return total_len;
    return lvl_end[sp];
  endfunction

  function automatic logic [4:0] pop_finished_levels();
    logic [4:0] n;
    n = 0;
    while (sp > 0 && sp <= DEPTH_LIMIT && !lvl_indef[sp] && pos >= lvl_end[sp]) begin
      sp = sp - 1;
      n  = n + 1;
    end
    if (sp == 0 && pos >= total_len) n = n + 1;
    return n;
  endfunction

  function automatic bit push_level(logic [31:0] end_pos, bit ind);
    if (sp + 1 > DEPTH_LIMIT) return 0;
    sp = sp + 1;
    lvl_end[sp]   = end_pos;
    lvl_indef[sp] = ind;
    return 1;
  endfunction

  function automatic logic [2:0] close_header(logic [31:0] len, bit ind, inout result_t r);
    logic [1:0]  cls;
    bit          cons;
    bit          eoc;
    logic [31:0] bnd;
    cls  = cls_form[2:1];
    cons = cls_form[0];
    bnd  = level_bound();
    len_acc       = len;
    r.header_done = 1;
    r.indefinite  = ind;
    if (!ind && ({32'b0, pos} + {32'b0, len}) > {32'b0, bnd}) return ST_OVERRUN;
    phase = PH_TAG_FIRST;
    if (!cons) begin
      if (len == 0) begin
        eoc = cls == 0 && tag_acc == 0 && sp > 0 && sp <= DEPTH_LIMIT && lvl_indef[sp];
        r.value_done = 1;
        if (eoc) begin
          sp = sp - 1;
          r.levels_closed = 5'd1 + pop_finished_levels();
        end else begin
          r.levels_closed = pop_finished_levels();
        end
      end else begin
        val_left = len;
        val_acc  = 0;
        phase    = PH_VALUE;
      end
    end else if (ind) begin
      if (!push_level(bnd, 1)) return ST_TOO_DEEP;
    end else if (len > 0) begin
      if (!push_level(pos + len, 0)) return ST_TOO_DEEP;
    end else begin
      r.levels_closed = pop_finished_levels();
    end
    return ST_OK;
  endfunction

  function automatic result_t decode_byte(logic [7:0] b);
    result_t    r;
    logic [2:0] st;
    logic [4:0] depth;
    logic [6:0] n;
    r     = '0;
    st    = ST_OK;
    depth = sp;
    if (sticky != ST_OK) begin
      r.byte_role = ROLE_IGNORE;
      r.status    = sticky;
    end else if (phase == PH_TAG_FIRST && sp == 0 && pos >= total_len) begin
      r.byte_role = ROLE_IGNORE;
      r.status    = ST_PAST_END;
    end else begin
      r.byte_role = phase == PH_VALUE ? ROLE_VALUE :
                    (phase == PH_TAG_FIRST || phase == PH_TAG_EXT) ? ROLE_TAG : ROLE_LENGTH;
      if (phase != PH_VALUE && pos >= level_bound()) begin
        st = ST_OVERRUN;
      end else if (phase == PH_VALUE) begin
        pos     = pos + 1;
        val_acc = {val_acc[55:0], b};
        if (val_left > 0) val_left = val_left - 1;
        if (val_left == 0) begin
          r.value_done    = 1;
          r.value_word    = len_acc <= 8 ? val_acc : 64'd0;
          phase           = PH_TAG_FIRST;
          r.levels_closed = pop_finished_levels();
        end
      end else begin
        pos = pos + 1;
        case (phase)
          PH_TAG_FIRST: begin
            cls_form = {b[7:6], b[5]};
            len_acc  = 0;
            ext_cnt  = 0;
            if (b[4:0] == TAG_ESCAPE) begin
              tag_acc = 0;
              phase   = PH_TAG_EXT;
            end else begin
              tag_acc = {16'b0, b[4:0]};
              phase   = PH_LEN_FIRST;
            end
          end
          PH_TAG_EXT: begin
            tag_acc = {tag_acc[13:0], b[6:0]};
            ext_cnt = ext_cnt + 1;
            if (!b[7]) phase = PH_LEN_FIRST;
            else if (ext_cnt >= 3) st = ST_TAG_LONG;
          end
          PH_LEN_FIRST: begin
            if (!b[7]) begin
              st = close_header({24'b0, b}, 0, r);
            end else begin
              n = b[6:0];
              if (n == 0) begin
                st = close_header(0, cls_form[0], r);
              end else if (n > LEN_BYTES) begin
                st = ST_LEN_LONG;
              end else begin
                len_acc  = 0;
                len_left = n[2:0];
                phase    = PH_LEN_MORE;
              end
            end
          end
          default: begin
            len_acc = {len_acc[23:0], b};
            if (len_left > 0) len_left = len_left - 1;
            if (len_left == 0) st = close_header(len_acc, 0, r);
          end
        endcase
      end
      r.tag_class    = cls_form[2:1];
      r.constructed  = cls_form[0];
      r.tag_number   = tag_acc;
      r.value_length = len_acc;
      r.nest_depth   = depth;
      if (st != ST_OK) begin
        sticky          = st;
        r.header_done   = 0;
        r.indefinite    = 0;
        r.value_word    = 0;
        r.value_done    = 0;
        r.levels_closed = 0;
      end
      r.status = st;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      total_len = 0;
      phase     = PH_TAG_FIRST;
      tag_acc   = 0;
      ext_cnt   = 0;
      cls_form  = 0;
      len_acc   = 0;
      len_left  = 0;
      val_left  = 0;
      val_acc   = 0;
      pos       = 0;
      sp        = 0;
      sticky    = ST_OK;
      for (int i = 0; i <= DEPTH_LIMIT; i++) begin
        lvl_end[i]   = 0;
        lvl_indef[i] = 0;
      end
      expected_results.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_wr_en) total_len = cfg_wr_data;
      if (res_mon.valid && res_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          checked++;
          compare_field("byte_role",     exp_r.byte_role,     res_mon.byte_role);
          compare_field("header_done",   exp_r.header_done,   res_mon.header_done);
          compare_field("tag_class",     exp_r.tag_class,     res_mon.tag_class);
          compare_field("constructed",   exp_r.constructed,   res_mon.constructed);
          compare_field("tag_number",    exp_r.tag_number,    res_mon.tag_number);
          compare_field("value_length",  exp_r.value_length,  res_mon.value_length);
          compare_field("indefinite",    exp_r.indefinite,    res_mon.indefinite);
          compare_field("nest_depth",    exp_r.nest_depth,    res_mon.nest_depth);
          compare_field("value_word",    exp_r.value_word,    res_mon.value_word);
          compare_field("value_done",    exp_r.value_done,    res_mon.value_done);
          compare_field("levels_closed", exp_r.levels_closed, res_mon.levels_closed);
          compare_field("status",        exp_r.status,        res_mon.status);
        end
      end
      if (byte_mon.valid && byte_mon.ready)
        expected_results.push_back(decode_byte(byte_mon.data_byte));
    end
    pending = expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives well-formed random BER encodings, directed corner cases and one
// closing fault into the TLV parser with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import btp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  int          fail_count;
  int          pending;
  int          checked;
  int          bytes_sent = 0;
  int          encodings = 0;
  int          burst_left = 0;
  int          fault_kind;
  logic [31:0] stream_pos = 0;

  btp_byte_if   byte_ch ();
  btp_result_if res_ch ();

  ber_tlv_stream_parser uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .byte_in(byte_ch), .result(res_ch)
  );

  btp_result_checker chk (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .byte_mon(byte_ch), .res_mon(res_ch),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always #6 clk = ~clk;

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    byte_ch.valid     = 0;
    byte_ch.data_byte = 0;
    res_ch.ready      = 0;
  end

  // receiver stall pattern
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: res_ch.ready = 1;
          1: res_ch.ready = $urandom_range(0, 1);
          2: res_ch.ready = $urandom_range(0, 3) == 0;
          default: res_ch.ready = $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  task automatic put_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(4, 12) : $urandom_range(0, 2);
      byte_ch.valid = 0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    byte_ch.valid     = 1;
    byte_ch.data_byte = b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
    byte_ch.valid = 0;
  endtask

  task automatic send_stream(logic [7:0] q[$]);
    foreach (q[i]) put_byte(q[i]);
  endtask

  task automatic drain_and_write(logic [31:0] val);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    cfg_wr_en   = 1;
    cfg_wr_data = val;
    @(negedge clk);
    cfg_wr_en   = 0;
  endtask

  task automatic send_encoding(logic [7:0] q[$], int past_end);
    logic [7:0] noise[$];
    drain_and_write(stream_pos + q.size());
    send_stream(q);
    stream_pos += q.size();
    encodings++;
    repeat (past_end) noise.push_back($urandom_range(0, 255));
    send_stream(noise);
  endtask

  function automatic void put_tag(ref logic [7:0] q[$], input logic [1:0] cls, input bit cons);
    int ext;
    ext = $urandom_range(0, 5);
    if (ext > 3) ext = 0;
    if (ext == 0) begin
      q.push_back({cls, cons, 5'(cls == 0 ? $urandom_range(1, 30) : $urandom_range(0, 30))});
    end else begin
      q.push_back({cls, cons, TAG_ESCAPE});
      for (int i = 0; i < ext; i++)
        q.push_back({i < ext - 1, 7'($urandom_range(0, 127))});
    end
  endfunction

  function automatic void put_length(ref logic [7:0] q[$], input int n);
    int nb;
    if (n < 128 && $urandom_range(0, 2) != 0) begin
      q.push_back(8'(n));
    end else begin
      nb = n < 256 ? 1 : (n < 65536 ? 2 : 3);
      nb = $urandom_range(nb, 4);
      q.push_back(8'h80 | 8'(nb));
      for (int i = nb - 1; i >= 0; i--) q.push_back(8'(n >> (8 * i)));
    end
  endfunction

  function automatic void put_tlv(ref logic [7:0] q[$], input int lvl);
    logic [7:0] body[$];
    logic [1:0] cls;
    bit         cons;
    int         n;
    cls  = $urandom_range(0, 3);
    cons = lvl < 4 && $urandom_range(0, 2) == 0;
    if (cons) begin
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) put_tlv(body, lvl + 1);
      put_tag(q, cls, 1);
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(8'h80);
        foreach (body[i]) q.push_back(body[i]);
        q.push_back(8'h00);
        q.push_back(8'h00);
        return;
      end
    end else begin
      n = $urandom_range(0, 7) == 0 ? $urandom_range(9, 20) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) body.push_back($urandom_range(0, 255));
      put_tag(q, cls, 0);
      if (n == 0 && $urandom_range(0, 2) == 0) begin
        q.push_back(8'h80);
        return;
      end
    end
    put_length(q, body.size());
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  initial begin
    logic [7:0] q[$];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // total_length of zero: everything is past the end
    drain_and_write(32'd0);
    send_stream('{8'h02, 8'hFF});

    q = '{8'h02, 8'h01, 8'hFF, 8'h04, 8'h00, 8'h05, 8'h80, 8'h00, 8'h00,
          8'h1F, 8'h05, 8'h01, 8'hAA, 8'h5F, 8'h81, 8'h01, 8'h02, 8'h00, 8'h01,
          8'hDF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h30, 8'h00,
          8'h30, 8'h80, 8'h02, 8'h01, 8'h05, 8'h00, 8'h00,
          8'h81, 8'h81, 8'h03, 8'h01, 8'h02, 8'h03,
          8'h82, 8'h82, 8'h00, 8'h02, 8'h11, 8'h22,
          8'h83, 8'h83, 8'h00, 8'h00, 8'h01, 8'h33,
          8'h04, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'h84, 8'h84, 8'h00, 8'h00, 8'h00, 8'h09,
          8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09};
    send_encoding(q, 1);

    // indefinite nesting to full depth, then definite nesting
    q = {};
    repeat (16) begin q.push_back(8'h30); q.push_back(8'h80); end
    q.push_back(8'h02); q.push_back(8'h01); q.push_back(8'h7F);
    repeat (16) begin q.push_back(8'h00); q.push_back(8'h00); end
    send_encoding(q, 0);
    send_encoding('{8'h30, 8'h06, 8'h31, 8'h04, 8'h02, 8'h02, 8'hFF, 8'hFF}, 2);

    while (bytes_sent < 880) begin
      q = {};
      put_tlv(q, 0);
      send_encoding(q, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
    end

    // one closing fault; every later byte is ignored
    drain_and_write(32'hFFFF_FFFF);
    fault_kind = $urandom_range(0, 3);
    case (fault_kind)
      0: q = '{8'h1F, 8'h81, 8'h82, 8'h83};
      1: q = '{8'h04, 8'h85};
      2: begin
        q = {};
        repeat (17) begin q.push_back(8'h30); q.push_back(8'h80); end
      end
      default: q = '{8'h30, 8'h03, 8'h04, 8'h05};
    endcase
    repeat (5) q.push_back($urandom_range(0, 255));
    send_stream(q);

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Covered %0d bytes in %0d encodings, %0d results checked, fault case %0d.",
             bytes_sent, encodings, checked, fault_kind);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
